// ===== rtl/core/jtc_pkg.sv =====
`timescale 1ns / 1ps

package jtc_pkg;

  localparam int IMG_WIDTH  = 512;
  localparam int IMG_HEIGHT = 512;
  localparam int MAX_ITER   = 48;

  localparam int PIX_W     = 9;
  localparam int Z_W       = 32;
  localparam int FRAC_BITS = 26;
  localparam int CNT_W     = $clog2(MAX_ITER + 1);

  // signed pixel offset from the image center
  localparam int DX_W = (($clog2(IMG_WIDTH) > PIX_W) ? $clog2(IMG_WIDTH) : PIX_W) + 1;
  localparam int DY_W = (($clog2(IMG_HEIGHT) > PIX_W) ? $clog2(IMG_HEIGHT) : PIX_W) + 1;

  localparam logic [63:0] ESCAPE_MAG2 = 64'd4 << (2 * FRAC_BITS);
  localparam logic [31:0] BLACK_RGBA  = 32'h0000_00FF;

  typedef struct packed {
    logic [Z_W-1:0]   zr;
    logic [Z_W-1:0]   zi;
    logic [CNT_W-1:0] cnt;
    logic             done;
  } jtc_item_t;

  function automatic logic [Z_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[Z_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/jtc_start.sv =====
`timescale 1ns / 1ps

module jtc_start (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [jtc_pkg::PIX_W-1:0]   pixel_x,
  input  logic [jtc_pkg::PIX_W-1:0]   pixel_y,
  input  logic [30:0]                 step_x,
  input  logic [30:0]                 step_y,
  input  logic signed [31:0]          offset_x,
  input  logic signed [31:0]          offset_y,
  output logic                        out_valid,
  output jtc_pkg::jtc_item_t          item
);
  import jtc_pkg::*;

  logic signed [DX_W-1:0]  dx;
  logic signed [DY_W-1:0]  dy;
  logic                    prod_valid;
  logic signed [DX_W+31:0] prod_x;
  logic signed [DY_W+31:0] prod_y;
  logic signed [DX_W+32:0] sum_x;
  logic signed [DY_W+32:0] sum_y;
  jtc_item_t               item_next;

  assign dx = $signed(DX_W'(pixel_x)) - $signed(DX_W'(IMG_WIDTH / 2));
  assign dy = $signed(DY_W'(pixel_y)) - $signed(DY_W'(IMG_HEIGHT / 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (en) begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

  always_comb begin
    sum_x          = (DX_W+33)'(prod_x) + (DX_W+33)'(offset_x);
    sum_y          = (DY_W+33)'(prod_y) + (DY_W+33)'(offset_y);
    item_next.zr   = sat32(64'(sum_x));
    item_next.zi   = sat32(64'(sum_y));
    item_next.cnt  = '0;
    item_next.done = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= dx * $signed({1'b0, step_x});
      prod_y <= dy * $signed({1'b0, step_y});
      item   <= item_next;
    end
  end

endmodule

// ===== rtl/core/jtc_iter.sv =====
`timescale 1ns / 1ps

module jtc_iter (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic signed [27:0] c_real,
  input  logic signed [27:0] c_imag,
  input  logic               in_valid,
  input  jtc_pkg::jtc_item_t in_item,
  output logic               out_valid,
  output jtc_pkg::jtc_item_t out_item
);
  import jtc_pkg::*;

  logic               mul_valid;
  jtc_item_t          mul_item;
  logic signed [63:0] rr;
  logic signed [63:0] ii;
  logic signed [63:0] ri;
  logic [63:0]        mag;
  logic signed [63:0] diff;
  logic               escape;
  jtc_item_t          item_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mul_valid <= in_valid;
      out_valid <= mul_valid;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (en) begin
      mul_item <= in_item;
      rr       <= $signed(in_item.zr) * $signed(in_item.zr);
      ii       <= $signed(in_item.zi) * $signed(in_item.zi);
      ri       <= $signed(in_item.zr) * $signed(in_item.zi);
    end
  end

  // escape test and update stage; an item that already escaped passes unchanged
  always_comb begin
    mag       = rr + ii;
    diff      = rr - ii;
    escape    = mag >= ESCAPE_MAG2;
    item_next = mul_item;
    if (!mul_item.done) begin
      if (escape) begin
        item_next.done = 1'b1;
      end else begin
        item_next.zr  = sat32((diff >>> FRAC_BITS) + 64'(c_real));
        item_next.zi  = sat32((ri >>> (FRAC_BITS - 1)) + 64'(c_imag));
        item_next.cnt = mul_item.cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== rtl/core/jtc_colour.sv =====
`timescale 1ns / 1ps

module jtc_colour (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  jtc_pkg::jtc_item_t in_item,
  output logic               out_valid,
  output logic [31:0]        rgba,
  output logic [5:0]         iter_count
);
  import jtc_pkg::*;

  localparam int PAL_SIZE  = 48;
  localparam int PAL_IDX_W = $clog2(PAL_SIZE);

  localparam logic [23:0] PALETTE [PAL_SIZE] = '{
    24'h03202F, 24'h041F37, 24'h051C3E, 24'h051746, 24'h06104E, 24'h070756,
    24'h13075E, 24'h210866, 24'h31086E, 24'h430975, 24'h570A7D, 24'h6D0A85,
    24'h840B8D, 24'h950C8C, 24'h9D0C80, 24'hA50D72, 24'hAC0E62, 24'hB40E51,
    24'hBC0F3D, 24'hC40F28, 24'hCC1010, 24'hD42B11, 24'hDC4711, 24'hE46612,
    24'hEB8613, 24'hECA61A, 24'hEDC422, 24'hEDE02A, 24'hE1EE32, 24'hCAEF3A,
    24'hB5EF42, 24'hA2F04A, 24'h91F052, 24'h82F159, 24'h75F261, 24'h69F269,
    24'h71F382, 24'h79F49A, 24'h81F4AF, 24'h89F5C2, 24'h90F6D4, 24'h98F6E3,
    24'hA0F7F1, 24'hA8F2F7, 24'hB0EAF8, 24'hB8E3F9, 24'hC0DEF9, 24'hC7DCFA
  };

  logic [31:0]          cnt_ext;
  logic [PAL_IDX_W-1:0] idx;
  logic [31:0]          rgba_next;

  always_comb begin
    cnt_ext = 32'(in_item.cnt);
    // clamp counts past the end of the palette to its last entry
    if (cnt_ext >= 32'(PAL_SIZE)) begin
      idx = PAL_IDX_W'(PAL_SIZE - 1);
    end else begin
      idx = cnt_ext[PAL_IDX_W-1:0];
    end
    if (cnt_ext == 32'(MAX_ITER)) begin
      rgba_next = BLACK_RGBA;
    end else begin
      rgba_next = {PALETTE[idx], 8'hFF};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rgba       <= rgba_next;
      iter_count <= cnt_ext[5:0];
    end
  end

endmodule

// ===== rtl/core/julia_escape_time_colourer_unit.sv =====
`timescale 1ns / 1ps
// Pipeline: 99 register stages lead from the accepting edge to m_tvalid, the first
// loaded at that edge: 2 start-point, 2 per cell for 48 cells, 1 color. A held result
// stalls the pipeline, skid parking included. Every cell has its own three multipliers.
// Throughput: one item per cycle while no result is held at the output.
// Reset: synchronous rst clears all valid bits and the skid valid flag and loads
// the register defaults; the block accepts items in the cycle after reset.
module julia_escape_time_colourer_unit (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // [8:0] pixel_x, [17:9] pixel_y, [23:18] zero
  // result stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // [31:0] rgba, [37:32] iter_count, [39:38] zero
);
  import jtc_pkg::*;

  localparam logic [2:0] REG_C_REAL   = 3'd0;
  localparam logic [2:0] REG_C_IMAG   = 3'd1;
  localparam logic [2:0] REG_STEP_X   = 3'd2;
  localparam logic [2:0] REG_STEP_Y   = 3'd3;
  localparam logic [2:0] REG_OFFSET_X = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y = 3'd5;

  logic signed [27:0] c_real;
  logic signed [27:0] c_imag;
  logic [30:0]        step_x;
  logic [30:0]        step_y;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic               cfg_write;

  logic               en;
  logic               skid_valid;
  logic [PIX_W-1:0]   skid_px;
  logic [PIX_W-1:0]   skid_py;
  logic               src_valid;
  logic [PIX_W-1:0]   src_px;
  logic [PIX_W-1:0]   src_py;

  logic               iv [MAX_ITER+1];
  jtc_item_t          iz [MAX_ITER+1];

  logic [31:0]        out_rgba;
  logic [5:0]         out_cnt;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real   <= -28'sd46976205;
      c_imag   <= 28'sd18129460;
      step_x   <= 31'd393216;
      step_y   <= 31'd262144;
      offset_x <= '0;
      offset_y <= '0;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_C_REAL:   c_real   <= pwdata[27:0];
        REG_C_IMAG:   c_imag   <= pwdata[27:0];
        REG_STEP_X:   step_x   <= pwdata[30:0];
        REG_STEP_Y:   step_y   <= pwdata[30:0];
        REG_OFFSET_X: offset_x <= pwdata;
        REG_OFFSET_Y: offset_y <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_C_REAL:   prdata = 32'(c_real);
      REG_C_IMAG:   prdata = 32'(c_imag);
      REG_STEP_X:   prdata = 32'(step_x);
      REG_STEP_Y:   prdata = 32'(step_y);
      REG_OFFSET_X: prdata = offset_x;
      REG_OFFSET_Y: prdata = offset_y;
      default:      prdata = '0;
    endcase
  end

  // whole pipeline advances unless a result is held at the output
  assign en       = !m_tvalid || m_tready;
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && s_tvalid && s_tready) begin
      skid_px <= s_tdata[PIX_W-1:0];
      skid_py <= s_tdata[2*PIX_W-1:PIX_W];
    end
  end

  always_comb begin
    if (skid_valid) begin
      src_valid = 1'b1;
      src_px    = skid_px;
      src_py    = skid_py;
    end else begin
      src_valid = s_tvalid;
      src_px    = s_tdata[PIX_W-1:0];
      src_py    = s_tdata[2*PIX_W-1:PIX_W];
    end
  end

  jtc_start u_start (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (src_valid),
    .pixel_x   (src_px),
    .pixel_y   (src_py),
    .step_x    (step_x),
    .step_y    (step_y),
    .offset_x  (offset_x),
    .offset_y  (offset_y),
    .out_valid (iv[0]),
    .item      (iz[0])
  );

  for (genvar k = 0; k < MAX_ITER; k++) begin : g_iter
    jtc_iter u_iter (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .c_real    (c_real),
      .c_imag    (c_imag),
      .in_valid  (iv[k]),
      .in_item   (iz[k]),
      .out_valid (iv[k+1]),
      .out_item  (iz[k+1])
    );
  end

  jtc_colour u_colour (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (iv[MAX_ITER]),
    .in_item    (iz[MAX_ITER]),
    .out_valid  (m_tvalid),
    .rgba       (out_rgba),
    .iter_count (out_cnt)
  );

  assign m_tdata = {2'b00, out_cnt, out_rgba};

  // a parked item holds until the pipeline moves
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !en |=> skid_valid && $stable(skid_px) && $stable(skid_py))
    else $error("skid item changed while stalled");

  // an item that never escaped has run every iteration
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    iv[MAX_ITER] && !iz[MAX_ITER].done |-> iz[MAX_ITER].cnt == CNT_W'(MAX_ITER))
    else $error("non-escaped item with short count");

  // non-escaped items come out black
  a_black: assert property (@(posedge clk) disable iff (rst)
    en && iv[MAX_ITER] && !iz[MAX_ITER].done |=> m_tvalid && m_tdata[31:0] == BLACK_RGBA)
    else $error("non-escaped item not black");

endmodule

// ===== tb/julia_result_checker.sv =====
`timescale 1ns / 1ps

package jtc_tb_pkg;

  // register index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_C_REAL,
    REG_C_IMAG,
    REG_STEP_X,
    REG_STEP_Y,
    REG_OFFSET_X,
    REG_OFFSET_Y,
    REG_SPARE_A,
    REG_SPARE_B
  } reg_index_e;

endpackage

module julia_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,  // [8:0] pixel_x, [17:9] pixel_y, [23:18] zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,  // [31:0] rgba, [37:32] iter_count, [39:38] zero
  output int          fail_count,
  output int          pixels_pending
);

  import jtc_pkg::*;
  import jtc_tb_pkg::*;

  localparam longint Q_MAX    = 64'sd2147483647;
  localparam longint Q_MIN    = -Q_MAX - 1;
  localparam int     RAMP_LEN = 48;
  localparam int     MAX_LINES = 50;

  // HSL ramp, 0xRRGGBB, entry 0 first
  localparam logic [0:RAMP_LEN-1][23:0] HSL_RAMP = {
    24'h03202F, 24'h041F37, 24'h051C3E, 24'h051746, 24'h06104E, 24'h070756,
    24'h13075E, 24'h210866, 24'h31086E, 24'h430975, 24'h570A7D, 24'h6D0A85,
    24'h840B8D, 24'h950C8C, 24'h9D0C80, 24'hA50D72, 24'hAC0E62, 24'hB40E51,
    24'hBC0F3D, 24'hC40F28, 24'hCC1010, 24'hD42B11, 24'hDC4711, 24'hE46612,
    24'hEB8613, 24'hECA61A, 24'hEDC422, 24'hEDE02A, 24'hE1EE32, 24'hCAEF3A,
    24'hB5EF42, 24'hA2F04A, 24'h91F052, 24'h82F159, 24'h75F261, 24'h69F269,
    24'h71F382, 24'h79F49A, 24'h81F4AF, 24'h89F5C2, 24'h90F6D4, 24'h98F6E3,
    24'hA0F7F1, 24'hA8F2F7, 24'hB0EAF8, 24'hB8E3F9, 24'hC0DEF9, 24'hC7DCFA
  };

  typedef struct {
    logic [31:0] rgba;
    logic [5:0]  count;
  } pixel_color_t;

  logic signed [27:0] c_re, c_im;
  logic [30:0]        step_re, step_im;
  logic signed [31:0] pan_re, pan_im;

  pixel_color_t color_queue[$];

  function automatic logic signed [31:0] clamp_q26(input longint v);
    if (v > Q_MAX) return Q_MAX[31:0];
    if (v < Q_MIN) return Q_MIN[31:0];
    return v[31:0];
  endfunction

  function automatic pixel_color_t shade_pixel(input logic [8:0] px, input logic [8:0] py);
    longint             rr, ii, ri;
    logic [63:0]        mag;
    logic signed [31:0] zr, zi;
    int                 n;
    bit                 escaped;
    pixel_color_t       res;
    zr = clamp_q26((longint'(px) - IMG_WIDTH / 2) * longint'(step_re) + longint'(pan_re));
    zi = clamp_q26((longint'(py) - IMG_HEIGHT / 2) * longint'(step_im) + longint'(pan_im));
    n = 0;
    escaped = 1'b0;
    while (!escaped && n < MAX_ITER) begin
      rr = longint'(zr) * longint'(zr);
      ii = longint'(zi) * longint'(zi);
      ri = longint'(zr) * longint'(zi);
      // magnitude sum can reach 2^63, compare unsigned
      mag = rr + ii;
      if (mag >= ESCAPE_MAG2) begin
        escaped = 1'b1;
      end else begin
        zr = clamp_q26(((rr - ii) >>> FRAC_BITS) + longint'(c_re));
        zi = clamp_q26((ri >>> (FRAC_BITS - 1)) + longint'(c_im));
        n++;
      end
    end
    res.count = n[5:0];
    if (n == MAX_ITER) begin
      res.rgba = BLACK_RGBA;
    end else begin
      res.rgba = {HSL_RAMP[(n < RAMP_LEN) ? n : RAMP_LEN - 1], 8'hFF};
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < MAX_LINES) begin
      $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    pixel_color_t want;
    if (rst) begin
      c_re       = -28'sd46976205;
      c_im       = 28'sd18129460;
      step_re    = 31'd393216;
      step_im    = 31'd262144;
      pan_re     = '0;
      pan_im     = '0;
      fail_count = 0;
      color_queue.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        color_queue.push_back(shade_pixel(s_tdata[8:0], s_tdata[17:9]));
      end
      if (m_tvalid && m_tready) begin
        if (color_queue.size() == 0) begin
          report_mismatch("unexpected item, rgba", m_tdata[31:0], 32'h0);
        end else begin
          want = color_queue.pop_front();
          if (m_tdata[31:0] !== want.rgba) begin
            report_mismatch("rgba", m_tdata[31:0], want.rgba);
          end
          if (m_tdata[37:32] !== want.count) begin
            report_mismatch("iter_count", {26'd0, m_tdata[37:32]}, {26'd0, want.count});
          end
          if (m_tdata[39:38] !== 2'b00) begin
            report_mismatch("tdata padding", {30'd0, m_tdata[39:38]}, 32'h0);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_C_REAL:   c_re    = pwdata[27:0];
          REG_C_IMAG:   c_im    = pwdata[27:0];
          REG_STEP_X:   step_re = pwdata[30:0];
          REG_STEP_Y:   step_im = pwdata[30:0];
          REG_OFFSET_X: pan_re  = pwdata;
          REG_OFFSET_Y: pan_im  = pwdata;
          default: ;
        endcase
      end
    end
    pixels_pending = color_queue.size();
  end

endmodule

// ===== tb/tb_julia_escape_time_colourer_unit.sv =====
`timescale 1ns / 1ps

module tb_julia_escape_time_colourer_unit;

  import jtc_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 155;
  localparam int RANDOM_PHASES = 8;
  localparam int IDLE_PCT = 18;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;    // [8:0] pixel_x, [17:9] pixel_y, [23:18] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // [31:0] rgba, [37:32] iter_count, [39:38] zero

  logic steady = 1'b0;
  int   fail_count;
  int   pixels_pending;
  int   cycle_count = 0;

  julia_escape_time_colourer_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  julia_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .fail_count     (fail_count),
    .pixels_pending (pixels_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // called and returns at a falling edge; tvalid stays high into the next item
  task automatic send_pixel(input logic [8:0] px, input logic [8:0] py);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid = 1'b0;
      s_tdata  = 24'($urandom);
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {6'd0, py, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the stream until every pixel in flight has come out
  task automatic drain_results();
    s_tvalid = 1'b0;
    while (pixels_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic load_settings(input logic [31:0] cr, input logic [31:0] ci,
                               input logic [31:0] sx, input logic [31:0] sy,
                               input logic [31:0] ox, input logic [31:0] oy);
    write_reg(REG_C_REAL, cr);
    write_reg(REG_C_IMAG, ci);
    write_reg(REG_STEP_X, sx);
    write_reg(REG_STEP_Y, sy);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
  endtask

  initial begin : stimulus
    int phase;
    int shift;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // default settings: corners, center, alternating bits
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd511);
    send_pixel(9'd0, 9'd511);
    send_pixel(9'd511, 9'd0);
    send_pixel(9'd256, 9'd256);
    send_pixel(9'h155, 9'h0AA);
    send_pixel(9'h0AA, 9'h155);
    drain_results();

    // largest steps and offsets: start points saturate
    load_settings(32'h0800_0000, 32'h07FF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF);
    send_pixel(9'd0, 9'd0);
    send_pixel(9'd511, 9'd511);
    send_pixel(9'd256, 9'd256);
    send_pixel(9'd300, 9'd10);
    drain_results();

    // zero steps and c = 0: z stays at the origin and never escapes
    load_settings(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_pixel(9'd17, 9'd400);
    send_pixel(9'd511, 9'd0);
    drain_results();

    // c = -2 lands on |z| = 2 after one step
    write_reg(REG_C_REAL, 32'h0800_0000);
    send_pixel(9'd5, 9'd6);
    drain_results();
    write_reg(REG_C_REAL, 32'h0);
    write_reg(REG_C_IMAG, 32'h07FF_FFFF);
    send_pixel(9'd5, 9'd6);
    drain_results();

    // |z| exactly 2 escapes at once, one lsb below does not
    write_reg(REG_C_IMAG, 32'h0);
    write_reg(REG_OFFSET_X, 32'h0800_0000);
    send_pixel(9'd100, 9'd100);
    drain_results();
    write_reg(REG_OFFSET_X, 32'h07FF_FFFF);
    send_pixel(9'd100, 9'd100);
    drain_results();

    // unmapped registers leave the settings alone
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    send_pixel(9'd200, 9'd300);
    drain_results();
    write_reg(REG_OFFSET_Y, 32'h8000_0000);
    send_pixel(9'd1, 9'd510);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      steady = (phase == 4);
      if (phase % 4 == 3) begin
        load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        // c within +-1, zoom in by up to 64x around a small pan
        shift = $urandom_range(6);
        load_settings($urandom_range(32'h0800_0000) - 32'h0400_0000,
                      $urandom_range(32'h0800_0000) - 32'h0400_0000,
                      32'd393216 >> shift, 32'd262144 >> shift,
                      $urandom_range(32'h0400_0000) - 32'h0200_0000,
                      $urandom_range(32'h0400_0000) - 32'h0200_0000);
      end
      if (phase == 6) begin
        write_reg(REG_STEP_X, 32'd1);
        write_reg(REG_STEP_Y, 32'd1);
      end
      repeat (PHASE_ITEMS) send_pixel(9'($urandom_range(511)), 9'($urandom_range(511)));
    end

    drain_results();
    steady = 1'b0;
    repeat (120) @(negedge clk);
    if (fail_count == 0 && pixels_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/jtc_pkg.sv
rtl/core/jtc_start.sv
rtl/core/jtc_iter.sv
rtl/core/jtc_colour.sv
rtl/core/julia_escape_time_colourer_unit.sv
tb/julia_result_checker.sv
tb/tb_julia_escape_time_colourer_unit.sv
